>>> hw/rtl/btc_pkg.sv
package btc_pkg;

  localparam int unsigned PRIME       = 10007;
  localparam int unsigned MOD_W       = 14;
  localparam int unsigned PROD_W      = 2 * MOD_W;
  localparam int unsigned QUO_W       = PROD_W - MOD_W + 1;
  localparam int unsigned COEF_W      = 20;
  localparam int unsigned EXP_W       = 10;
  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned MUL_LAT     = 3;

  // Barrett constant, floor(2^28 / p)
  localparam int unsigned BARRETT_MU  = (1 << PROD_W) / PRIME;

  typedef struct packed {
    logic             bad;
    logic [EXP_W-1:0] n;
    logic [EXP_W-1:0] m;
  } side_t;

endpackage

>>> hw/rtl/btc_if.sv
interface btc_in_if;
  import btc_pkg::*;

  logic              valid;
  logic              ready;
  logic [COEF_W-1:0] coef_a;
  logic [COEF_W-1:0] coef_b;
  logic [EXP_W-1:0]  total_power;
  logic [EXP_W-1:0]  power_x;
  logic [EXP_W-1:0]  power_y;

  modport source (output valid, coef_a, coef_b, total_power, power_x, power_y, input ready);
  modport sink   (input valid, coef_a, coef_b, total_power, power_x, power_y, output ready);
endinterface

interface btc_out_if;
  import btc_pkg::*;

  logic             valid;
  logic             ready;
  logic [MOD_W-1:0] coefficient;
  logic             invalid;

  modport source (output valid, coefficient, invalid, input ready);
  modport sink   (input valid, coefficient, invalid, output ready);
endinterface

>>> hw/rtl/binomial_term_coefficient_mod.sv
// Coefficient of x^n*y^m in (a*x+b*y)^k mod 10007, i.e. C(k,n)*a^n*b^m.
// Fully pipelined: one word per clock is accepted whenever the output word
// is taken or empty. A reduction round is followed by twelve chained modular
// multiplies (ten square-and-multiply rounds, then two product steps), each a
// 3-stage Barrett multiplier. Factorial and inverse-factorial tables are ROMs
// fixed at build time; no initialization pass after reset. power_x > total_power
// or total_power >= TABLE_DEPTH gives invalid = 1 with coefficient = 0.
module binomial_term_coefficient_mod #(
  parameter int unsigned TABLE_DEPTH = btc_pkg::TABLE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  btc_in_if.sink    din,
  btc_out_if.source dout
);
  import btc_pkg::*;

  localparam int unsigned LAT = MUL_LAT * (EXP_W + 3);

  logic             en;
  logic [LAT-1:0]   vpipe;
  logic             out_valid;
  logic [MOD_W-1:0] out_coef;
  logic             out_bad;

  assign en        = !out_valid || dout.ready;
  assign din.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe     <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vpipe     <= {vpipe[LAT-2:0], din.valid};
      out_valid <= vpipe[LAT-1];
    end
  end

  // reduction round
  side_t             side_in;
  logic [COEF_W-1:0] a_q;
  logic [COEF_W-1:0] b_q;
  logic [MOD_W-1:0]  a_red;
  logic [MOD_W-1:0]  b_red;
  logic [MOD_W-1:0]  f1, i1, j1;
  logic [MOD_W-1:0]  f3, i3, j3, j6;

  assign side_in.bad = (din.power_x > din.total_power) ||
                       (32'(din.total_power) >= TABLE_DEPTH);
  assign side_in.n   = din.power_x;
  assign side_in.m   = din.power_y;

  always_ff @(posedge clk) begin
    if (en) begin
      a_q <= din.coef_a;
      b_q <= din.coef_b;
    end
  end

  btc_reduce u_ra (.clk(clk), .en(en), .x(PROD_W'(a_q)), .r(a_red));
  btc_reduce u_rb (.clk(clk), .en(en), .x(PROD_W'(b_q)), .r(b_red));

  btc_rom #(.TableDepth(TABLE_DEPTH)) u_rom (
    .clk(clk), .en(en), .k(din.total_power), .n(din.power_x),
    .fact_k(f1), .inv_n(i1), .inv_kn(j1)
  );

  btc_shift #(.W(3*MOD_W), .N(MUL_LAT-1)) u_rom_d (
    .clk(clk), .en(en), .d({f1, i1, j1}), .q({f3, i3, j3})
  );

  side_t side [EXP_W+1];

  btc_shift #(.W($bits(side_t)), .N(MUL_LAT)) u_side0 (
    .clk(clk), .en(en), .d(side_in), .q(side[0])
  );

  // binomial from tables
  logic [MOD_W-1:0] t1;
  logic [MOD_W-1:0] binom;
  logic [MOD_W-1:0] binom_d;

  btc_mulmod u_b1 (.clk(clk), .en(en), .x(f3), .y(i3), .r(t1));
  btc_shift #(.W(MOD_W), .N(MUL_LAT)) u_j_d (.clk(clk), .en(en), .d(j3), .q(j6));
  btc_mulmod u_b2 (.clk(clk), .en(en), .x(t1), .y(j6), .r(binom));
  btc_shift #(.W(MOD_W), .N(MUL_LAT*(EXP_W-2))) u_binom_d (
    .clk(clk), .en(en), .d(binom), .q(binom_d)
  );

  // square-and-multiply rounds, one exponent bit per round
  logic [MOD_W-1:0] acc_a  [EXP_W+1];
  logic [MOD_W-1:0] acc_b  [EXP_W+1];
  logic [MOD_W-1:0] base_a [EXP_W];
  logic [MOD_W-1:0] base_b [EXP_W];

  assign acc_a[0]  = MOD_W'(1);
  assign acc_b[0]  = MOD_W'(1);
  assign base_a[0] = a_red;
  assign base_b[0] = b_red;

  for (genvar i = 0; i < EXP_W; i++) begin : g_round
    logic [MOD_W-1:0] ya;
    logic [MOD_W-1:0] yb;

    assign ya = side[i].n[i] ? base_a[i] : MOD_W'(1);
    assign yb = side[i].m[i] ? base_b[i] : MOD_W'(1);

    btc_mulmod u_ma (.clk(clk), .en(en), .x(acc_a[i]), .y(ya), .r(acc_a[i+1]));
    btc_mulmod u_mb (.clk(clk), .en(en), .x(acc_b[i]), .y(yb), .r(acc_b[i+1]));

    if (i < EXP_W - 1) begin : g_sq
      btc_mulmod u_sa (.clk(clk), .en(en), .x(base_a[i]), .y(base_a[i]), .r(base_a[i+1]));
      btc_mulmod u_sb (.clk(clk), .en(en), .x(base_b[i]), .y(base_b[i]), .r(base_b[i+1]));
    end

    btc_shift #(.W($bits(side_t)), .N(MUL_LAT)) u_side (
      .clk(clk), .en(en), .d(side[i]), .q(side[i+1])
    );
  end

  // final products
  logic [MOD_W-1:0] v1;
  logic [MOD_W-1:0] v2;
  logic [MOD_W-1:0] pb_d;
  side_t            side_f;

  btc_mulmod u_f1 (.clk(clk), .en(en), .x(binom_d), .y(acc_a[EXP_W]), .r(v1));
  btc_shift #(.W(MOD_W), .N(MUL_LAT)) u_pb_d (
    .clk(clk), .en(en), .d(acc_b[EXP_W]), .q(pb_d)
  );
  btc_mulmod u_f2 (.clk(clk), .en(en), .x(v1), .y(pb_d), .r(v2));
  btc_shift #(.W($bits(side_t)), .N(2*MUL_LAT)) u_side_f (
    .clk(clk), .en(en), .d(side[EXP_W]), .q(side_f)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      out_coef <= side_f.bad ? '0 : v2;
      out_bad  <= side_f.bad;
    end
  end

  assign dout.valid       = out_valid;
  assign dout.coefficient = out_coef;
  assign dout.invalid     = out_bad;
endmodule

>>> hw/rtl/btc_shift.sv
module btc_shift #(
  parameter int unsigned W = 1,
  parameter int unsigned N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);
  logic [W-1:0] sr [N];

  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= d;
      for (int i = 1; i < int'(N); i++) begin
        sr[i] <= sr[i-1];
      end
    end
  end

  assign q = sr[N-1];
endmodule

>>> hw/rtl/btc_reduce.sv
module btc_reduce (
  input  logic                          clk,
  input  logic                          en,
  input  logic [btc_pkg::PROD_W-1:0]    x,
  output logic [btc_pkg::MOD_W-1:0]     r
);
  import btc_pkg::*;

  logic [PROD_W-1:0]   x_q;
  logic [QUO_W-1:0]    q_q;
  logic [2*QUO_W-1:0]  qm;
  logic [PROD_W:0]     qp;
  logic [QUO_W-1:0]    r0;
  logic [QUO_W-1:0]    r1;
  logic [QUO_W-1:0]    r2;

  // quotient estimate, low by at most two
  assign qm = (2*QUO_W)'(x[PROD_W-1:MOD_W-1]) * (2*QUO_W)'(BARRETT_MU);

  always_ff @(posedge clk) begin
    if (en) begin
      x_q <= x;
      q_q <= qm[2*QUO_W-1:QUO_W];
    end
  end

  assign qp = (PROD_W+1)'(q_q) * (PROD_W+1)'(PRIME);
  assign r0 = QUO_W'({1'b0, x_q} - qp);
  assign r1 = (r0 >= QUO_W'(PRIME)) ? r0 - QUO_W'(PRIME) : r0;
  assign r2 = (r1 >= QUO_W'(PRIME)) ? r1 - QUO_W'(PRIME) : r1;

  always_ff @(posedge clk) begin
    if (en) begin
      r <= MOD_W'(r2);
    end
  end
endmodule

>>> hw/rtl/btc_mulmod.sv
module btc_mulmod (
  input  logic                       clk,
  input  logic                       en,
  input  logic [btc_pkg::MOD_W-1:0]  x,
  input  logic [btc_pkg::MOD_W-1:0]  y,
  output logic [btc_pkg::MOD_W-1:0]  r
);
  import btc_pkg::*;

  logic [PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_W'(x) * PROD_W'(y);
    end
  end

  btc_reduce u_red (.clk(clk), .en(en), .x(prod), .r(r));
endmodule

>>> hw/rtl/btc_rom.sv
module btc_rom #(
  parameter int unsigned TableDepth = btc_pkg::TABLE_DEPTH
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [btc_pkg::EXP_W-1:0]  k,
  input  logic [btc_pkg::EXP_W-1:0]  n,
  output logic [btc_pkg::MOD_W-1:0]  fact_k,
  output logic [btc_pkg::MOD_W-1:0]  inv_n,
  output logic [btc_pkg::MOD_W-1:0]  inv_kn
);
  import btc_pkg::*;

  localparam int unsigned AW = (TableDepth > 1) ? $clog2(TableDepth) : 1;

  typedef logic [MOD_W-1:0] tab_t [TableDepth];

  function automatic tab_t build_fact();
    tab_t        t;
    int unsigned acc;
    acc  = 1;
    t[0] = MOD_W'(acc);
    for (int unsigned i = 1; i < TableDepth; i++) begin
      acc  = (acc * i) % PRIME;
      t[i] = MOD_W'(acc);
    end
    return t;
  endfunction

  function automatic tab_t build_inv();
    tab_t        t;
    int unsigned f;
    int unsigned base;
    int unsigned e;
    int unsigned acc;
    f = 1;
    for (int unsigned i = 1; i < TableDepth; i++) begin
      f = (f * i) % PRIME;
    end
    base = f;
    e    = PRIME - 2;
    acc  = 1;
    while (e != 0) begin
      if (e[0]) begin
        acc = (acc * base) % PRIME;
      end
      base = (base * base) % PRIME;
      e    = e >> 1;
    end
    t[TableDepth-1] = MOD_W'(acc);
    for (int unsigned i = TableDepth - 1; i > 0; i--) begin
      acc      = (acc * i) % PRIME;
      t[i-1]   = MOD_W'(acc);
    end
    return t;
  endfunction

  localparam tab_t FactTab = build_fact();
  localparam tab_t InvTab  = build_inv();

  logic [EXP_W-1:0] kn;

  assign kn = k - n;

  always_ff @(posedge clk) begin
    if (en) begin
      fact_k <= FactTab[AW'(k)];
      inv_n  <= InvTab[AW'(n)];
      inv_kn <= InvTab[AW'(kn)];
    end
  end
endmodule

>>> hw/rtl/btc_checker.sv
module btc_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [btc_pkg::MOD_W-1:0] out_coef,
  input logic                      out_bad
);
  import btc_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word present after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_coef) && $stable(out_bad))
    else $error("stalled output word changed");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_coef < MOD_W'(PRIME))
    else $error("coefficient not reduced");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_bad |-> out_coef == '0)
    else $error("invalid word with nonzero coefficient");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");
endmodule

bind binomial_term_coefficient_mod btc_checker u_btc_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(din.ready),
  .out_valid(dout.valid),
  .out_ready(dout.ready),
  .out_coef(dout.coefficient),
  .out_bad(dout.invalid)
);
